/* src/tnfe_pkg.sv */
// ----------------------------------------------------------------------------
// tnfe_pkg
// Shared types and constants of the tagged numeric field extractor.
// ----------------------------------------------------------------------------
package tnfe_pkg;

  // Configuration port widths and register indexes.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LOW    = 3'd0,
    REG_PATTERN_HIGH   = 3'd1,
    REG_PATTERN_LENGTH = 3'd2,
    REG_ALLOW_POINT    = 3'd3,
    REG_BUFFER_SPACE   = 3'd4,
    REG_FIELD_SLOT     = 3'd5
  } reg_index_t;

  // Field widths.
  localparam int BYTE_W   = 8;
  localparam int PLEN_W   = 5;
  localparam int COUNT_W  = 8;
  localparam int SLOT_W   = 4;
  localparam int KIND_W   = 2;

  // Reset values of the configuration registers.
  localparam logic [PLEN_W-1:0]  PLEN_RESET   = 5'd1;
  localparam logic [COUNT_W-1:0] SPACE_RESET  = 8'd255;

  // Characters of interest.
  localparam logic [BYTE_W-1:0] CH_LT    = 8'h3C;
  localparam logic [BYTE_W-1:0] CH_POINT = 8'h2E;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

  typedef enum logic [KIND_W-1:0] {
    KIND_CHAR = 2'd0,
    KIND_DONE = 2'd1,
    KIND_FAIL = 2'd2
  } result_kind_t;

  typedef enum logic [2:0] {
    PH_SEARCH  = 3'b001,
    PH_COLLECT = 3'b010,
    PH_DONE    = 3'b100
  } phase_t;

  // One result item.
  typedef struct packed {
    result_kind_t        kind;
    logic [BYTE_W-1:0]   value_char;
    logic [COUNT_W-1:0]  value_length;
    logic [SLOT_W-1:0]   slot;
  } result_t;

endpackage

/* src/tnfe_if.sv */
// ----------------------------------------------------------------------------
// tnfe_if
// Valid/ready channel interfaces: text bytes in, results out, register writes.
// ----------------------------------------------------------------------------
interface tnfe_in_if;
  import tnfe_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] byte_value;
  logic              last_byte;

  modport source (output valid, output byte_value, output last_byte, input ready);
  modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

interface tnfe_out_if;
  import tnfe_pkg::*;
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  result_kind;
  logic [BYTE_W-1:0]  value_char;
  logic [COUNT_W-1:0] value_length;
  logic [SLOT_W-1:0]  slot_out;

  modport source (output valid, output result_kind, output value_char,
                  output value_length, output slot_out, input ready);
  modport sink   (input valid, input result_kind, input value_char,
                  input value_length, input slot_out, output ready);
endinterface

interface tnfe_cfg_if;
  import tnfe_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wr_data;

  modport source (output valid, output reg_index, output wr_data, input ready);
  modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

/* src/tagged_numeric_field_extractor_unit.sv */
// ----------------------------------------------------------------------------
// tagged_numeric_field_extractor_unit
// Scans a text frame for a tag and extracts the numeric value after it.
// ----------------------------------------------------------------------------
// The unit takes one text byte per clock cycle while its output buffer
// has room, and gives its result (if any) through that buffer. The byte is
// classified, the tag window compared and the phase updated combinationally;
// the result goes into a two-entry output buffer, so input is taken while one
// result waits and stalls only once two results are held. Up to MAX_PATTERN
// tag bytes (at most 16) are matched in parallel against a window of the most
// recent bytes. Register writes are always taken and must only happen while
// the unit is idle.
module tagged_numeric_field_extractor_unit #(
  parameter int MAX_PATTERN = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  tnfe_in_if.sink    in_ch,
  tnfe_out_if.source out_ch,
  tnfe_cfg_if.sink   cfg_ch
);
  import tnfe_pkg::*;

  localparam int SEEN_W = $clog2(MAX_PATTERN + 1);

  // Configuration registers.
  logic [CFG_DATA_W-1:0] pattern_low_r;
  logic [CFG_DATA_W-1:0] pattern_high_r;
  logic [PLEN_W-1:0]     pattern_length_r;
  logic                  allow_point_r;
  logic [COUNT_W-1:0]    buffer_space_r;
  logic [SLOT_W-1:0]     field_slot_r;

  // Scan state.
  logic [MAX_PATTERN-1:0][BYTE_W-1:0] window_r, window_nxt;
  logic [SEEN_W-1:0]                  seen_r, seen_nxt;
  phase_t                             phase_r, phase_nxt;
  logic [COUNT_W-1:0]                 count_r, count_nxt;

  logic        accept;
  logic        can_push;
  logic        tag_match;
  logic        is_val;
  logic        emit;
  result_t     res;
  result_t     out_data;
  logic [BYTE_W-1:0] b;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = can_push;
  assign accept       = in_ch.valid && can_push;
  assign b            = in_ch.byte_value;

  // Register writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_low_r    <= '0;
      pattern_high_r   <= '0;
      pattern_length_r <= PLEN_RESET;
      allow_point_r    <= 1'b0;
      buffer_space_r   <= SPACE_RESET;
      field_slot_r     <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.reg_index)
        REG_PATTERN_LOW:    pattern_low_r    <= cfg_ch.wr_data;
        REG_PATTERN_HIGH:   pattern_high_r   <= cfg_ch.wr_data;
        REG_PATTERN_LENGTH: pattern_length_r <= cfg_ch.wr_data[PLEN_W-1:0];
        REG_ALLOW_POINT:    allow_point_r    <= cfg_ch.wr_data[0];
        REG_BUFFER_SPACE:   buffer_space_r   <= cfg_ch.wr_data[COUNT_W-1:0];
        REG_FIELD_SLOT:     field_slot_r     <= cfg_ch.wr_data[SLOT_W-1:0];
        default: ;
      endcase
    end
  end

  // The window shifts in the new byte; slot 0 holds the newest byte.
  always_comb begin
    window_nxt[0] = b;
    for (int k = 1; k < MAX_PATTERN; k++) begin
      window_nxt[k] = window_r[k-1];
    end
  end

  tnfe_tag_match #(
    .MAX_PATTERN (MAX_PATTERN),
    .SEEN_W      (SEEN_W)
  ) u_tag_match (
    .window         (window_nxt),
    .seen           (seen_nxt),
    .pattern_low    (pattern_low_r),
    .pattern_high   (pattern_high_r),
    .pattern_length (pattern_length_r),
    .match          (tag_match)
  );

  assign is_val = ((b >= CH_ZERO) && (b <= CH_NINE)) || (allow_point_r && (b == CH_POINT));

  // Bytes seen in the frame, saturating at the window depth.
  always_comb begin
    if (seen_r < SEEN_W'(MAX_PATTERN)) begin
      seen_nxt = seen_r + SEEN_W'(1);
    end else begin
      seen_nxt = seen_r;
    end
  end

  // Phase machine and result selection for the byte being transferred.
  always_comb begin
    logic [COUNT_W-1:0] cnt;
    phase_t             ph;
    cnt  = count_r;
    ph   = phase_r;
    emit = 1'b0;
    res.kind       = KIND_FAIL;
    res.value_char = '0;
    unique case (phase_r)
      PH_SEARCH: begin
        if (tag_match) begin
          ph  = PH_COLLECT;
          cnt = '0;
        end
        emit = in_ch.last_byte;
      end
      PH_COLLECT: begin
        if (count_r >= buffer_space_r) begin
          emit = 1'b1;
          ph   = PH_DONE;
        end else if (is_val) begin
          emit = 1'b1;
          if (in_ch.last_byte) begin
            ph = PH_DONE;
          end else begin
            cnt            = count_r + COUNT_W'(1);
            res.kind       = KIND_CHAR;
            res.value_char = b;
          end
        end else if (b == CH_LT) begin
          if (count_r != '0) begin
            emit     = 1'b1;
            res.kind = KIND_DONE;
            ph       = PH_DONE;
          end else if (in_ch.last_byte) begin
            emit = 1'b1;
            ph   = PH_DONE;
          end
        end else begin
          emit = 1'b1;
          ph   = PH_DONE;
        end
      end
      PH_DONE: begin
      end
      default: begin
      end
    endcase
    res.value_length = cnt;
    res.slot         = field_slot_r;

    // The end of a frame always returns to searching.
    if (in_ch.last_byte) begin
      phase_nxt = PH_SEARCH;
      count_nxt = '0;
    end else begin
      phase_nxt = ph;
      count_nxt = cnt;
    end
  end

  // Scan control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SEARCH;
      count_r <= '0;
      seen_r  <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      if (in_ch.last_byte) begin
        seen_r <= '0;
      end else if (phase_r == PH_SEARCH) begin
        seen_r <= seen_nxt;
      end
    end
  end

  // Window bytes are only compared once the seen count covers them.
  always_ff @(posedge clk) begin
    if (accept && (phase_r == PH_SEARCH)) begin
      window_r <= window_nxt;
    end
  end

  tnfe_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept && emit),
    .push_data (res),
    .can_push  (can_push),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_data)
  );

  assign out_ch.result_kind  = out_data.kind;
  assign out_ch.value_char   = out_data.value_char;
  assign out_ch.value_length = out_data.value_length;
  assign out_ch.slot_out     = out_data.slot;

endmodule

/* src/tnfe_tag_match.sv */
// ----------------------------------------------------------------------------
// tnfe_tag_match
// Parallel compare of the recent-byte window against the configured tag.
// ----------------------------------------------------------------------------
module tnfe_tag_match #(
  parameter int MAX_PATTERN = 16,
  parameter int SEEN_W      = 5
) (
  input  logic [MAX_PATTERN-1:0][tnfe_pkg::BYTE_W-1:0] window,
  input  logic [SEEN_W-1:0]                           seen,
  input  logic [tnfe_pkg::CFG_DATA_W-1:0]             pattern_low,
  input  logic [tnfe_pkg::CFG_DATA_W-1:0]             pattern_high,
  input  logic [tnfe_pkg::PLEN_W-1:0]                 pattern_length,
  output logic                                        match
);
  import tnfe_pkg::*;

  logic [PLEN_W-1:0] eff_len;

  // Pick byte idx of the sixteen-byte pattern.
  function automatic logic [BYTE_W-1:0] pat_byte(input logic [CFG_DATA_W-1:0] lo,
                                                 input logic [CFG_DATA_W-1:0] hi,
                                                 input logic [3:0] idx);
    logic [CFG_DATA_W-1:0] w;
    w = idx[3] ? hi : lo;
    return w[idx[2:0]*BYTE_W +: BYTE_W];
  endfunction

  // Length zero counts as one; lengths beyond the window are clamped.
  always_comb begin
    if (pattern_length == '0) begin
      eff_len = PLEN_W'(1);
    end else if (pattern_length > PLEN_W'(MAX_PATTERN)) begin
      eff_len = PLEN_W'(MAX_PATTERN);
    end else begin
      eff_len = pattern_length;
    end
  end

  // Window slot j (newest is slot 0) must equal pattern byte eff_len-1-j.
  always_comb begin
    logic [PLEN_W-1:0] idx;
    match = (PLEN_W'(seen) >= eff_len);
    for (int j = 0; j < MAX_PATTERN; j++) begin
      idx = eff_len - PLEN_W'(1) - PLEN_W'(j);
      if (PLEN_W'(j) < eff_len) begin
        if (window[j] != pat_byte(pattern_low, pattern_high, idx[3:0])) begin
          match = 1'b0;
        end
      end
    end
  end

endmodule

/* src/tnfe_out_buf.sv */
// ----------------------------------------------------------------------------
// tnfe_out_buf
// Two-entry output buffer: an output register backed by one skid register.
// ----------------------------------------------------------------------------
module tnfe_out_buf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  tnfe_pkg::result_t   push_data,
  output logic                can_push,
  output logic                out_valid,
  input  logic                out_ready,
  output tnfe_pkg::result_t   out_data
);
  import tnfe_pkg::*;

  logic    out_valid_r, out_valid_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  result_t out_data_r, out_data_nxt;
  result_t skid_data_r, skid_data_nxt;
  logic    pop;

  assign pop       = out_valid_r && out_ready;
  assign can_push  = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Next-state of the two slots; the skid slot only fills while the output stalls.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      if (pop) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (out_valid_r) begin
      if (pop && push) begin
        out_data_nxt = push_data;
      end else if (pop) begin
        out_valid_nxt = 1'b0;
      end else if (push) begin
        skid_data_nxt  = push_data;
        skid_valid_nxt = 1'b1;
      end
    end else if (push) begin
      out_data_nxt  = push_data;
      out_valid_nxt = 1'b1;
    end
  end

  // Control flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

endmodule

/* src/tnfe_checker.sv */
// ----------------------------------------------------------------------------
// tnfe_checker
// Port-level checks of the extractor, bound to the top level.
// ----------------------------------------------------------------------------
module tnfe_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [tnfe_pkg::KIND_W-1:0]  result_kind,
  input logic [tnfe_pkg::BYTE_W-1:0]  value_char,
  input logic [tnfe_pkg::COUNT_W-1:0] value_length,
  input logic [tnfe_pkg::SLOT_W-1:0]  slot_out
);
  import tnfe_pkg::*;

  // A stalled result keeps its payload until transferred.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(result_kind) && $stable(value_char) &&
       $stable(value_length) && $stable(slot_out)))
    else $error("stalled result changed");

  // Input stalls only when a result is waiting at the output.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with empty output");

  // Completion and failure carry no character.
  a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (result_kind != KIND_CHAR)) |-> (value_char == '0))
    else $error("character on non-character result");

  // A completed value or a passed character always has a nonzero length.
  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ((result_kind == KIND_DONE) || (result_kind == KIND_CHAR)))
      |-> (value_length != '0))
    else $error("zero length on character or completion");

endmodule

bind tagged_numeric_field_extractor_unit tnfe_checker u_tnfe_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .result_kind  (out_ch.result_kind),
  .value_char   (out_ch.value_char),
  .value_length (out_ch.value_length),
  .slot_out     (out_ch.slot_out)
);

/* tb/tnfe_result_checker.sv */
// ----------------------------------------------------------------------------
// tnfe_result_checker
// Watches the byte, result and register channels of the field extractor,
// keeps its own copy of the registers and the scan state, works out the
// result of every byte transfer and compares each result transfer with the
// oldest value still owed.
// ----------------------------------------------------------------------------
module tnfe_result_checker #(
  parameter int MAX_TAG = 16
) (
  input  logic clk,
  input  logic rst_n,
  tnfe_in_if   in_mon,
  tnfe_out_if  out_mon,
  tnfe_cfg_if  cfg_mon,
  output int   results_outstanding,
  output int   mismatch_count
);
  import tnfe_pkg::*;

  // Register copies.
  logic [63:0]        tag_low;
  logic [63:0]        tag_high;
  logic [PLEN_W-1:0]  tag_length;
  logic               point_ok;
  logic [COUNT_W-1:0] space_left;
  logic [SLOT_W-1:0]  slot_cfg;

  // Scan state; window[0] holds the newest byte.
  logic [BYTE_W-1:0]  window [16];
  logic [4:0]         bytes_seen;
  phase_t             scan_phase;
  logic [COUNT_W-1:0] char_count;

  result_t            expected_results [$];
  result_t            want;

  function automatic logic [BYTE_W-1:0] tag_byte(input int i);
    if (i < 8) return tag_low[8*i +: 8];
    return tag_high[8*(i-8) +: 8];
  endfunction

  // A length of zero means one byte; anything above the maximum is clipped.
  function automatic logic tag_in_window();
    int n;
    n = (tag_length == 0) ? 1 : ((tag_length > MAX_TAG) ? MAX_TAG : int'(tag_length));
    if (n > 16) n = 16;
    if (bytes_seen < n) return 1'b0;
    for (int i = 0; i < n; i++)
      if (window[n-1-i] !== tag_byte(i)) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void restart_frame();
    foreach (window[i]) window[i] = '0;
    bytes_seen = '0;
    scan_phase = PH_SEARCH;
    char_count = '0;
  endfunction

  function automatic void owe_result(input result_kind_t kind, input logic [BYTE_W-1:0] ch);
    result_t r;
    r.kind         = kind;
    r.value_char   = ch;
    r.value_length = char_count;
    r.slot         = slot_cfg;
    expected_results.push_back(r);
  endfunction

  // Works out the effect of one text byte on the scan state and the result it owes.
  function automatic void extract_from_byte(input logic [BYTE_W-1:0] b, input logic last);
    logic is_value;
    is_value = (b >= CH_ZERO && b <= CH_NINE) || (point_ok && b == CH_POINT);
    unique case (scan_phase)
      PH_SEARCH: begin
        for (int i = 15; i > 0; i--) window[i] = window[i-1];
        window[0] = b;
        if (bytes_seen < 16) bytes_seen = bytes_seen + 5'd1;
        if (tag_in_window()) begin
          scan_phase = PH_COLLECT;
          char_count = '0;
        end
        if (last) owe_result(KIND_FAIL, '0);
      end
      PH_COLLECT: begin
        if (char_count >= space_left) begin
          owe_result(KIND_FAIL, '0);
          scan_phase = PH_DONE;
        end else if (is_value) begin
          if (last) begin
            owe_result(KIND_FAIL, '0);
            scan_phase = PH_DONE;
          end else begin
            char_count = char_count + 8'd1;
            owe_result(KIND_CHAR, b);
          end
        end else if (b == CH_LT) begin
          // A '<' before any character is skipped, unless it is the last byte.
          if (char_count > 0) begin
            owe_result(KIND_DONE, '0);
            scan_phase = PH_DONE;
          end else if (last) begin
            owe_result(KIND_FAIL, '0);
            scan_phase = PH_DONE;
          end
        end else begin
          owe_result(KIND_FAIL, '0);
          scan_phase = PH_DONE;
        end
      end
      default: ;
    endcase
    if (last) restart_frame();
  endfunction

  function automatic void check_field(input string name, input logic [7:0] expected_v,
                                      input logic [7:0] actual_v);
    if (actual_v !== expected_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, expected_v, actual_v);
      mismatch_count++;
    end
  endfunction

  // Result transfers are checked before the byte transfer of the same edge is
  // predicted, since a result always belongs to an earlier byte.
  always @(posedge clk) begin
    if (!rst_n) begin
      tag_low    = '0;
      tag_high   = '0;
      tag_length = PLEN_RESET;
      point_ok   = 1'b0;
      space_left = SPACE_RESET;
      slot_cfg   = '0;
      restart_frame();
      expected_results.delete();
      mismatch_count = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_results.size() == 0) begin
          $error("Result transfer with nothing owed: kind %0d, length %0d",
                 out_mon.result_kind, out_mon.value_length);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("result_kind", 8'(want.kind), 8'(out_mon.result_kind));
          check_field("value_char", want.value_char, out_mon.value_char);
          check_field("value_length", want.value_length, out_mon.value_length);
          check_field("slot_out", 8'(want.slot), 8'(out_mon.slot_out));
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        unique case (reg_index_t'(cfg_mon.reg_index))
          REG_PATTERN_LOW:    tag_low    = cfg_mon.wr_data;
          REG_PATTERN_HIGH:   tag_high   = cfg_mon.wr_data;
          REG_PATTERN_LENGTH: tag_length = cfg_mon.wr_data[PLEN_W-1:0];
          REG_ALLOW_POINT:    point_ok   = cfg_mon.wr_data[0];
          REG_BUFFER_SPACE:   space_left = cfg_mon.wr_data[COUNT_W-1:0];
          REG_FIELD_SLOT:     slot_cfg   = cfg_mon.wr_data[SLOT_W-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        extract_from_byte(in_mon.byte_value, in_mon.last_byte);
    end
    results_outstanding <= expected_results.size();
  end

endmodule

/* tb/tagged_numeric_field_extractor_unit_tb.sv */
// ----------------------------------------------------------------------------
// tagged_numeric_field_extractor_unit_tb
// Drives text frames into the field extractor under several register
// settings: a short directed set of frames covering each way a value can
// complete or fail, then random frames that are mostly well formed (noise,
// tag, value, end marker) with broken and tag-less frames mixed in. Both
// channels stall at random; a separate checker predicts and compares.
// ----------------------------------------------------------------------------
module tagged_numeric_field_extractor_unit_tb;
  import tnfe_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 6;

  logic clk = 1'b0;
  logic rst_n;

  tnfe_in_if  in_ch ();
  tnfe_out_if out_ch ();
  tnfe_cfg_if cfg_ch ();

  int results_outstanding;
  int mismatch_count;
  int cycle_count = 0;
  int send_idle_pct;
  int recv_idle_pct;

  // Stimulus copy of the current tag and value limits.
  logic [BYTE_W-1:0] tag_bytes [16];
  int                tag_len;
  logic              point_mode;
  int                space_cfg;
  logic [BYTE_W-1:0] frame_q [$];

  tagged_numeric_field_extractor_unit #(.MAX_PATTERN(16)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  tnfe_result_checker #(.MAX_TAG(16)) u_result_check (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_mon              (in_ch),
    .out_mon             (out_ch),
    .cfg_mon             (cfg_ch),
    .results_outstanding (results_outstanding),
    .mismatch_count      (mismatch_count)
  );

  always #(CLK_HALF) clk = ~clk;

  // Receiver stalls at random.
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Guard against a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Presents one register write; the caller lowers valid after its last write.
  task automatic write_reg(input reg_index_t idx, input logic [63:0] data);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wr_data   <= data;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic apply_setting(input logic [63:0] lo, input logic [63:0] hi,
                               input logic [4:0] plen, input logic point,
                               input logic [7:0] space, input logic [3:0] slot);
    write_reg(REG_PATTERN_LOW, lo);
    write_reg(REG_PATTERN_HIGH, hi);
    write_reg(REG_PATTERN_LENGTH, 64'(plen));
    write_reg(REG_ALLOW_POINT, 64'(point));
    write_reg(REG_BUFFER_SPACE, 64'(space));
    write_reg(REG_FIELD_SLOT, 64'(slot));
    cfg_ch.valid <= 1'b0;
    for (int i = 0; i < 8; i++) begin
      tag_bytes[i]   = lo[8*i +: 8];
      tag_bytes[i+8] = hi[8*i +: 8];
    end
    tag_len    = (plen == 0) ? 1 : ((plen > 16) ? 16 : int'(plen));
    point_mode = point;
    space_cfg  = space;
  endtask

  // One byte transfer, after a random number of idle cycles.
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.byte_value <= b;
    in_ch.last_byte  <= last;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_q.size(); i++)
      send_byte(frame_q[i], i == frame_q.size() - 1);
    frame_q.delete();
  endtask

  // Holds the sender off until every owed result has been taken; the extra
  // cycles cover bytes that owe nothing but may still be in flight.
  task automatic wait_until_drained();
    in_ch.valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (results_outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [63:0] letter_word();
    logic [63:0] w;
    for (int i = 0; i < 8; i++) w[8*i +: 8] = 8'h61 + 8'($urandom_range(25));
    return w;
  endfunction

  // Noise leans towards tag bytes so that partial tags turn up.
  function automatic logic [BYTE_W-1:0] noise_byte();
    if ($urandom_range(3) == 0) return tag_bytes[$urandom_range(tag_len - 1)];
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [BYTE_W-1:0] bad_byte();
    logic [BYTE_W-1:0] b;
    unique case ($urandom_range(4))
      0: b = CH_ZERO - 8'd1;
      1: b = CH_NINE + 8'd1;
      2: b = CH_POINT;
      default: begin
        b = 8'($urandom_range(255));
        while ((b >= CH_ZERO && b <= CH_NINE) || b == CH_POINT || b == CH_LT)
          b = 8'($urandom_range(255));
      end
    endcase
    return b;
  endfunction

  // Value lengths hug the buffer limit when that limit is small.
  function automatic int value_size();
    if (space_cfg <= 8 && $urandom_range(1) == 0) return $urandom_range(space_cfg + 1, 1);
    return $urandom_range(6, 1);
  endfunction

  task automatic push_tag();
    for (int i = 0; i < tag_len; i++) frame_q.push_back(tag_bytes[i]);
  endtask

  task automatic push_value(input int count);
    for (int i = 0; i < count; i++)
      if (point_mode && $urandom_range(4) == 0) frame_q.push_back(CH_POINT);
      else frame_q.push_back(CH_ZERO + 8'($urandom_range(9)));
  endtask

  // Random frames: mostly well formed, then bad bytes, frames ending inside
  // the value or right after the tag, and frames without a tag.
  task automatic run_frames(input int byte_budget);
    int sent;
    int pick;
    sent = 0;
    while (sent < byte_budget) begin
      pick = $urandom_range(99);
      repeat ($urandom_range(3)) frame_q.push_back(noise_byte());
      if (pick >= 90) begin
        repeat ($urandom_range(6, 1)) frame_q.push_back(noise_byte());
      end else begin
        push_tag();
        if (pick < 85) begin
          if ($urandom_range(3) == 0) frame_q.push_back(CH_LT);
          push_value(value_size());
        end
        if (pick < 65) frame_q.push_back(CH_LT);
        else if (pick < 80) frame_q.push_back(bad_byte());
        if (pick < 80) repeat ($urandom_range(3)) frame_q.push_back(noise_byte());
      end
      sent += frame_q.size();
      send_frame();
      if ($urandom_range(11) == 0) wait_until_drained();
    end
  endtask

  initial begin
    in_ch.valid      <= 1'b0;
    in_ch.byte_value <= '0;
    in_ch.last_byte  <= 1'b0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.reg_index <= REG_PATTERN_LOW;
    cfg_ch.wr_data   <= '0;
    rst_n            <= 1'b0;
    send_idle_pct = 32;
    recv_idle_pct = 48;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frames: three-letter tag, real mode, widest buffer.
    apply_setting(letter_word(), letter_word(), 5'd3, 1'b1, 8'd255, 4'd0);
    // Extreme bytes before the tag, then a value with a point.
    frame_q = '{8'h00, 8'hFF};
    push_tag();
    frame_q.push_back(CH_ZERO + 8'd1);
    frame_q.push_back(CH_ZERO + 8'd2);
    frame_q.push_back(CH_POINT);
    frame_q.push_back(CH_NINE);
    frame_q.push_back(CH_LT);
    send_frame();
    // Leading '<' is skipped; bytes after completion are ignored.
    frame_q.push_back(CH_LT);
    push_tag();
    frame_q.push_back(CH_LT);
    frame_q.push_back(CH_ZERO);
    frame_q.push_back(CH_NINE);
    frame_q.push_back(CH_LT);
    frame_q.push_back(8'hFF);
    send_frame();
    // Tag ends on the last byte of the frame.
    push_tag();
    send_frame();
    // Frame ends without a tag.
    frame_q = '{8'h00, 8'hFF};
    send_frame();
    // Last byte is a digit: only the failure comes out.
    push_tag();
    frame_q.push_back(CH_ZERO + 8'd5);
    send_frame();
    // Byte just above '9' breaks the value; the digit after it is ignored.
    push_tag();
    frame_q.push_back(CH_NINE + 8'd1);
    frame_q.push_back(CH_ZERO);
    send_frame();
    // A '<' with no characters on the last byte.
    push_tag();
    frame_q.push_back(CH_LT);
    send_frame();
    run_frames(50);
    wait_until_drained();

    // Single-byte tag, integer mode, room for one character only.
    apply_setting(letter_word(), 64'd0, 5'd1, 1'b0, 8'd1, 4'd15);
    run_frames(50);
    wait_until_drained();

    send_idle_pct = 48;
    recv_idle_pct = 32;
    // Full-length tag of arbitrary bytes, small buffer.
    apply_setting({$urandom, $urandom}, {$urandom, $urandom}, 5'd16, 1'b1, 8'd4, 4'd7);
    run_frames(50);
    wait_until_drained();

    // Zero tag length acts as one byte; zero buffer fails at once.
    apply_setting(letter_word(), letter_word(), 5'd0, 1'b0, 8'd0, 4'd3);
    run_frames(50);
    wait_until_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    // Length above the maximum is clipped; tag of sixteen 0xFF bytes.
    apply_setting('1, '1, 5'd20, 1'b1, 8'd255, 4'd9);
    // Overflow of the widest buffer.
    push_tag();
    push_value(256);
    frame_q.push_back(CH_LT);
    send_frame();
    run_frames(50);
    wait_until_drained();

    apply_setting(letter_word(), letter_word(), 5'd5, 1'b0, 8'd8, 4'd12);
    run_frames(50);
    wait_until_drained();

    if (mismatch_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
